// ===== hw/rtl/morse_key_decoder_core_defines.svh =====
// assertion macros for the morse key decoder
`ifndef MORSE_KEY_DECODER_CORE_DEFINES_SVH
`define MORSE_KEY_DECODER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MKD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mkd same-cycle check failed");

// next-cycle implication, checked out of reset
`define MKD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mkd next-cycle check failed");

`endif

// ===== hw/rtl/mkd_pkg.sv =====
// shared types, constants and the code match function of the morse key decoder
`timescale 1ns / 1ps
`default_nettype none

package mkd_pkg;

	// symbol buffer sizing
	localparam int MAX_SYMBOLS = 5;
	localparam int SYM_W = MAX_SYMBOLS + 1;
	localparam int CNT_W = $clog2(SYM_W + 1);
	localparam int IDX_W = $clog2(SYM_W);

	localparam int LEN_W = 16;
	localparam logic [LEN_W-1:0] THRESHOLD_RESET = 16'd5000;

	// event codes
	typedef enum logic [1:0] {
		MODE_PRESS  = 2'd0,
		MODE_COMMIT = 2'd1,
		MODE_CLEAR  = 2'd2
	} mode_t;

	// ascii codes
	localparam logic [6:0] CHAR_SPACE    = 7'h20;
	localparam logic [6:0] CHAR_QUESTION = 7'h3F;
	localparam logic [6:0] CHAR_LETTER_A = 7'h41;
	localparam logic [6:0] CHAR_DIGIT_0  = 7'h30;

	// code table: letters a to z, then digits 0 to 9; symbol k in bit k, 1 for dash
	localparam int CODE_COUNT = 36;
	localparam int LETTER_COUNT = 26;

	localparam logic [2:0] CODE_LEN [CODE_COUNT] = '{
		3'd2, 3'd4, 3'd4, 3'd3, 3'd1,
		3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
		3'd3, 3'd4, 3'd2, 3'd2, 3'd3,
		3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
		3'd3, 3'd4, 3'd3, 3'd4, 3'd4,
		3'd4,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5
	};

	localparam logic [4:0] CODE_BITS [CODE_COUNT] = '{
		5'h02, 5'h01, 5'h05, 5'h01, 5'h00,
		5'h04, 5'h03, 5'h00, 5'h00, 5'h0E,
		5'h05, 5'h02, 5'h03, 5'h01, 5'h07,
		5'h06, 5'h0B, 5'h02, 5'h00, 5'h01,
		5'h04, 5'h08, 5'h06, 5'h09, 5'h0D,
		5'h03,
		5'h1F, 5'h1E, 5'h1C, 5'h18, 5'h10,
		5'h00, 5'h01, 5'h03, 5'h07, 5'h0F
	};

	// one input item
	typedef struct packed {
		logic [1:0]       mode;
		logic [LEN_W-1:0] press_length;
	} key_item_t;

	// one result item
	typedef struct packed {
		logic       char_valid;
		logic [6:0] char_code;
		logic       symbol_long;
		logic       overflow;
	} result_t;

	// match the symbol buffer against all codes in parallel
	function automatic logic [6:0] decode_char(
		input logic [SYM_W-1:0] bits,
		input logic [CNT_W-1:0] count
	);
		logic [6:0] ch;
		logic       found;
		ch = CHAR_QUESTION;
		found = 1'b0;
		if (count == '0) begin
			ch = CHAR_SPACE;
		end else begin
			for (int k = 0; k < CODE_COUNT; k++) begin
				if (!found && CNT_W'(CODE_LEN[k]) == count
						&& SYM_W'(CODE_BITS[k]) == bits) begin
					found = 1'b1;
					if (k < LETTER_COUNT) begin
						ch = CHAR_LETTER_A + 7'(k);
					end else begin
						ch = CHAR_DIGIT_0 + 7'(k - LETTER_COUNT);
					end
				end
			end
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mkd_ingress.sv =====
// input register stage of the morse key decoder
`timescale 1ns / 1ps
`default_nettype none

module mkd_ingress (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              key_valid,
	output logic                   key_stall,
	input  wire mkd_pkg::key_item_t key_item,
	input  wire logic              advance,
	output logic                   valid_s1,
	output mkd_pkg::key_item_t     item_s1
);

	logic accept;

	// hold off only when the stage is full and cannot move on
	assign key_stall = valid_s1 && !advance;
	assign accept = key_valid && !key_stall;

	// stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= key_item;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mkd_symbol_engine.sv =====
// symbol buffer state, press classification and character match
`timescale 1ns / 1ps
`default_nettype none

module mkd_symbol_engine (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [mkd_pkg::LEN_W-1:0]  cfg_wr_data,
	input  wire logic                       fire,
	input  wire mkd_pkg::key_item_t         item_s1,
	output mkd_pkg::result_t                result
);

	logic [mkd_pkg::LEN_W-1:0] threshold_q;
	logic [mkd_pkg::SYM_W-1:0] symbol_bits_q, symbol_bits_d;
	logic [mkd_pkg::CNT_W-1:0] symbol_count_q, symbol_count_d;
	logic                      overflow_q, overflow_d;
	logic                      dash;
	logic                      store;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= mkd_pkg::THRESHOLD_RESET;
		end else if (cfg_wr_en) begin
			threshold_q <= cfg_wr_data;
		end
	end

	assign dash = item_s1.press_length >= threshold_q;
	assign store = !overflow_q
		&& (symbol_count_q <= mkd_pkg::CNT_W'(mkd_pkg::MAX_SYMBOLS));

	// next buffer state and result
	always_comb begin
		symbol_bits_d = symbol_bits_q;
		symbol_count_d = symbol_count_q;
		overflow_d = overflow_q;
		result = '0;
		result.overflow = overflow_q;
		unique case (item_s1.mode)
			mkd_pkg::MODE_PRESS: begin
				result.symbol_long = dash;
				if (store) begin
					symbol_bits_d[symbol_count_q[mkd_pkg::IDX_W-1:0]] = dash;
					symbol_count_d = symbol_count_q + 1'b1;
					if (symbol_count_d > mkd_pkg::CNT_W'(mkd_pkg::MAX_SYMBOLS)) begin
						overflow_d = 1'b1;
					end
				end
				result.overflow = overflow_d;
			end
			mkd_pkg::MODE_COMMIT: begin
				result.char_valid = 1'b1;
				result.char_code = mkd_pkg::decode_char(symbol_bits_q, symbol_count_q);
				symbol_bits_d = '0;
				symbol_count_d = '0;
				overflow_d = 1'b0;
			end
			mkd_pkg::MODE_CLEAR: begin
				symbol_bits_d = '0;
				symbol_count_d = '0;
			end
			default: begin
			end
		endcase
	end

	// buffer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_bits_q <= '0;
			symbol_count_q <= '0;
			overflow_q <= 1'b0;
		end else if (fire) begin
			symbol_bits_q <= symbol_bits_d;
			symbol_count_q <= symbol_count_d;
			overflow_q <= overflow_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mkd_result_reg.sv =====
// result register of the morse key decoder
`timescale 1ns / 1ps
`default_nettype none

module mkd_result_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire mkd_pkg::result_t result,
	output logic                  out_free,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output mkd_pkg::result_t      res_q
);

	// slot frees when empty or when the held item is taken
	assign out_free = !res_valid || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (out_free) begin
			res_valid <= load;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/morse_key_decoder_core.sv =====
// top level of the morse key decoder
//
//   channel   | handshake            | payload
//   ----------+----------------------+--------------------------------------------
//   key in    | key_valid, key_stall | mode, press_length
//   result    | res_valid, res_stall | char_valid, char_code, symbol_long, overflow
//   config    | cfg_wr_en            | cfg_wr_data (press threshold)
//
// one item per cycle while the result side does not stall; a taken item passes through
// the input register, then match logic into the result register
// the buffer state updates as an item leaves the input register
// reset clears the buffer, the valid flags and sets the threshold to 5000
// a stalled result holds; one more item then waits in the input register
`timescale 1ns / 1ps
`default_nettype none
`include "morse_key_decoder_core_defines.svh"

module morse_key_decoder_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [mkd_pkg::LEN_W-1:0] cfg_wr_data,
	input  wire logic                      key_valid,
	output logic                           key_stall,
	input  wire logic [1:0]                mode,
	input  wire logic [mkd_pkg::LEN_W-1:0] press_length,
	output logic                           res_valid,
	input  wire logic                      res_stall,
	output logic                           char_valid,
	output logic [6:0]                     char_code,
	output logic                           symbol_long,
	output logic                           overflow
);

	mkd_pkg::key_item_t key_item;
	mkd_pkg::key_item_t item_s1;
	mkd_pkg::result_t   result;
	mkd_pkg::result_t   res_q;
	logic               valid_s1;
	logic               out_free;
	logic               fire;

	assign key_item.mode = mode;
	assign key_item.press_length = press_length;
	assign fire = valid_s1 && out_free;

	// input register
	mkd_ingress u_ingress (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.key_stall (key_stall),
		.key_item  (key_item),
		.advance   (out_free),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	// buffer state and match
	mkd_symbol_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fire        (fire),
		.item_s1     (item_s1),
		.result      (result)
	);

	// result register
	mkd_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.result    (result),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_q     (res_q)
	);

	assign char_valid = res_q.char_valid;
	assign char_code = res_q.char_code;
	assign symbol_long = res_q.symbol_long;
	assign overflow = res_q.overflow;

	// checks
	`MKD_ASSERT_NOW(a_stall_needs_item, clk, arst_n, key_stall, valid_s1)
	`MKD_ASSERT_NEXT(a_item_reaches_result, clk, arst_n, valid_s1 && !res_valid, res_valid)
	`MKD_ASSERT_NOW(a_commit_no_symbol, clk, arst_n, res_valid && char_valid, !symbol_long)
	`MKD_ASSERT_NOW(a_code_only_on_commit, clk, arst_n, res_valid && !char_valid, char_code == 7'd0)

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for the morse key decoder core
`timescale 1ns / 1ps

module testbench;
	import mkd_pkg::*;

	localparam logic [1:0] MODE_RESERVED = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int PRINT_LIMIT = 50;
	localparam int PHASE_ITEMS = 290;
	localparam int PHASE_COUNT = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [LEN_W-1:0] cfg_wr_data = '0;
	logic key_valid = 1'b0;
	logic key_stall;
	logic [1:0] mode = MODE_PRESS;
	logic [LEN_W-1:0] press_length = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic char_valid;
	logic [6:0] char_code;
	logic symbol_long;
	logic overflow;

	morse_key_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.key_valid(key_valid),
		.key_stall(key_stall),
		.mode(mode),
		.press_length(press_length),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.char_valid(char_valid),
		.char_code(char_code),
		.symbol_long(symbol_long),
		.overflow(overflow)
	);

	// pending key items and expected decoder results
	key_item_t pending_keys[$];
	result_t expected_results[$];
	int unsigned queued_count = 0;
	int unsigned taken_count = 0;
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;

	// handshake flags from the last rising edge
	logic key_taken = 1'b0;
	logic res_taken = 1'b0;

	// pacing of both sides
	int unsigned key_gap = 0;
	int unsigned stall_left = 0;
	bit key_burst = 1'b0;
	bit res_burst = 1'b0;

	// decoder state as predicted
	logic [LEN_W-1:0] key_threshold = THRESHOLD_RESET;
	logic [MAX_SYMBOLS:0] held_symbols = '0;
	logic [2:0] held_count = '0;
	logic held_overflow = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// standard morse codes, letters then digits
	function automatic string morse_of(input int k);
		case (k)
			0: return ".-";      1: return "-...";    2: return "-.-.";    3: return "-..";
			4: return ".";       5: return "..-.";    6: return "--.";     7: return "....";
			8: return "..";      9: return ".---";    10: return "-.-";    11: return ".-..";
			12: return "--";     13: return "-.";     14: return "---";    15: return ".--.";
			16: return "--.-";   17: return ".-.";    18: return "...";    19: return "-";
			20: return "..-";    21: return "...-";   22: return ".--";    23: return "-..-";
			24: return "-.--";   25: return "--..";   26: return "-----";  27: return ".----";
			28: return "..---";  29: return "...--";  30: return "....-";  31: return ".....";
			32: return "-....";  33: return "--...";  34: return "---..";  default: return "----.";
		endcase
	endfunction

	// character for the held symbols
	function automatic logic [6:0] lookup_char(input logic [MAX_SYMBOLS:0] bits,
			input logic [2:0] count);
		string keyed;
		keyed = "";
		if (count == 0) return CHAR_SPACE;
		for (int i = 0; i < count; i++) begin
			if (bits[i]) keyed = {keyed, "-"};
			else keyed = {keyed, "."};
		end
		for (int k = 0; k < CODE_COUNT; k++) begin
			if (morse_of(k) == keyed) begin
				if (k < LETTER_COUNT) return CHAR_LETTER_A + 7'(k);
				return CHAR_DIGIT_0 + 7'(k - LETTER_COUNT);
			end
		end
		return CHAR_QUESTION;
	endfunction

	// next decoder result; advances the predicted symbol buffer
	function automatic result_t decode_key(input key_item_t it);
		result_t r;
		r = '0;
		case (it.mode)
			MODE_PRESS: begin
				r.symbol_long = (it.press_length >= key_threshold);
				if (!held_overflow && held_count <= MAX_SYMBOLS) begin
					held_symbols[held_count] = r.symbol_long;
					held_count = held_count + 3'd1;
					if (held_count > MAX_SYMBOLS) held_overflow = 1'b1;
				end
				r.overflow = held_overflow;
			end
			MODE_COMMIT: begin
				r.char_valid = 1'b1;
				r.char_code = lookup_char(held_symbols, held_count);
				r.overflow = held_overflow;
				held_symbols = '0;
				held_count = '0;
				held_overflow = 1'b0;
			end
			MODE_CLEAR: begin
				held_symbols = '0;
				held_count = '0;
				r.overflow = held_overflow;
			end
			default: begin
				r.overflow = held_overflow;
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
	endtask

	// key side driver
	always @(negedge clk) begin : key_driver
		key_item_t it;
		if (!arst_n) begin
			key_valid <= 1'b0;
		end else if (!key_valid || key_taken) begin
			if (key_gap > 0) begin
				key_valid <= 1'b0;
				key_gap--;
			end else if (pending_keys.size() > 0) begin
				it = pending_keys.pop_front();
				key_valid <= 1'b1;
				mode <= it.mode;
				press_length <= it.press_length;
				if ($urandom_range(0, 39) == 0) key_burst = !key_burst;
				key_gap = key_burst ? 0 : $urandom_range(0, 8);
			end else begin
				key_valid <= 1'b0;
			end
		end
	end

	// result side stall
	always @(negedge clk) begin
		if (res_taken) begin
			if ($urandom_range(0, 39) == 0) res_burst = !res_burst;
			stall_left = res_burst ? 0 : $urandom_range(0, 8);
		end
		if (stall_left > 0) begin
			res_stall <= 1'b1;
			stall_left--;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// monitor: predict on key items, check on results, watchdog
	always @(posedge clk) begin : monitor
		result_t want;
		key_item_t it;
		logic key_fire;
		logic res_fire;
		key_fire = arst_n && key_valid && !key_stall;
		res_fire = arst_n && res_valid && !res_stall;
		key_taken <= key_fire;
		res_taken <= res_fire;
		if (res_fire) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", char_code, 0);
			end else begin
				want = expected_results.pop_front();
				if (char_valid !== want.char_valid)
					report_mismatch("char_valid", char_valid, want.char_valid);
				if (char_code !== want.char_code)
					report_mismatch("char_code", char_code, want.char_code);
				if (symbol_long !== want.symbol_long)
					report_mismatch("symbol_long", symbol_long, want.symbol_long);
				if (overflow !== want.overflow)
					report_mismatch("overflow", overflow, want.overflow);
			end
		end
		if (key_fire) begin
			it.mode = mode;
			it.press_length = press_length;
			expected_results.push_back(decode_key(it));
			taken_count++;
		end
		if (!arst_n || key_fire || res_fire) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("morse_key_decoder_core regression: fail");
			$finish;
		end
	end

	task automatic queue_key(input logic [1:0] m, input logic [LEN_W-1:0] len);
		key_item_t it;
		it.mode = m;
		it.press_length = len;
		pending_keys.push_back(it);
		queued_count++;
	endtask

	// press length on the requested side of the threshold (any length when the threshold is zero), boundaries now and then
	function automatic logic [LEN_W-1:0] key_len(input bit dash);
		if (dash) begin
			if ($urandom_range(0, 7) == 0) return key_threshold;
			return LEN_W'($urandom_range(16'hFFFF, key_threshold));
		end
		if (key_threshold == 0) return LEN_W'($urandom_range(0, 16'hFFFF));
		if ($urandom_range(0, 7) == 0) return key_threshold - 16'd1;
		return LEN_W'($urandom_range(key_threshold - 16'd1, 0));
	endfunction

	// one random character, a broken sequence, a cleared sequence, or a stray item
	task automatic queue_random_burst();
		int unsigned kind;
		int unsigned n;
		string code;
		kind = $urandom_range(0, 99);
		if (kind < 65) begin
			code = morse_of($urandom_range(0, 35));
			for (int i = 0; i < code.len(); i++) queue_key(MODE_PRESS, key_len(code[i] == "-"));
			queue_key(MODE_COMMIT, LEN_W'($urandom_range(0, 16'hFFFF)));
		end else if (kind < 80) begin
			n = $urandom_range(0, 8);
			for (int i = 0; i < n; i++) queue_key(MODE_PRESS, key_len(1'($urandom_range(0, 1))));
			queue_key(MODE_COMMIT, LEN_W'($urandom_range(0, 16'hFFFF)));
		end else if (kind < 88) begin
			n = $urandom_range(1, 7);
			for (int i = 0; i < n; i++) queue_key(MODE_PRESS, key_len(1'($urandom_range(0, 1))));
			queue_key(MODE_CLEAR, LEN_W'($urandom_range(0, 16'hFFFF)));
			n = $urandom_range(0, 3);
			for (int i = 0; i < n; i++) queue_key(MODE_PRESS, key_len(1'($urandom_range(0, 1))));
			queue_key(MODE_COMMIT, LEN_W'($urandom_range(0, 16'hFFFF)));
		end else begin
			queue_key(2'($urandom_range(0, 3)), LEN_W'($urandom_range(0, 16'hFFFF)));
		end
	endtask

	// hold off until every result is back, then let the pipeline settle
	task automatic wait_idle();
		do @(negedge clk);
		while (taken_count != queued_count || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [LEN_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		key_threshold = value;
	endtask

	// stimulus
	initial begin
		int unsigned phase_end;
		logic [LEN_W-1:0] setting;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed items at the reset threshold
		queue_key(MODE_PRESS, 16'h0000);
		queue_key(MODE_PRESS, 16'hFFFF);
		queue_key(MODE_COMMIT, 16'h0000);
		// empty buffer gives a space
		queue_key(MODE_COMMIT, 16'hFFFF);
		// threshold boundaries: dash then three dots
		queue_key(MODE_PRESS, THRESHOLD_RESET);
		for (int i = 0; i < 3; i++) queue_key(MODE_PRESS, THRESHOLD_RESET - 16'd1);
		queue_key(MODE_COMMIT, 16'h0000);
		// overflow, press while overflowed, clear keeps the flag
		for (int i = 0; i < 6; i++) queue_key(MODE_PRESS, 16'd1);
		queue_key(MODE_PRESS, 16'hFFFF);
		queue_key(MODE_CLEAR, 16'h0000);
		queue_key(MODE_COMMIT, 16'h0000);
		// reserved mode
		queue_key(MODE_RESERVED, 16'hFFFF);
		// no matching code
		for (int i = 0; i < 4; i++) queue_key(MODE_PRESS, 16'hFFFF);
		queue_key(MODE_COMMIT, 16'h0000);
		wait_idle();

		// random phases over several thresholds
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: setting = 16'd1;
				1: setting = 16'hFFFF;
				2: setting = 16'd0;
				4: setting = THRESHOLD_RESET;
				default: setting = LEN_W'($urandom_range(2, 16'hFFFE));
			endcase
			write_threshold(setting);
			phase_end = queued_count + PHASE_ITEMS;
			while (queued_count < phase_end) queue_random_burst();
			wait_idle();
		end

		if (mismatches == 0) begin
			$display("morse_key_decoder_core regression: pass");
		end else begin
			$display("morse_key_decoder_core regression: fail");
		end
		$finish;
	end

endmodule
